// ===== hdl/ata_pkg.sv =====
package ata_pkg;

    localparam int unsigned SECTOR_WORDS_DEF = 256;
    localparam int unsigned SETTLE_READS_DEF = 4;
    localparam int unsigned MAX_RES = 8;
    localparam logic [19:0] POLL_LIMIT_RST = 20'd1000000;

    localparam logic [2:0] OP_PROBE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_RET   = 3'd3;
    localparam logic [2:0] OP_WDATA = 3'd4;

    localparam logic [2:0] K_RD   = 3'd0;
    localparam logic [2:0] K_WR   = 3'd1;
    localparam logic [2:0] K_HOST = 3'd2;
    localparam logic [2:0] K_OPEN = 3'd3;
    localparam logic [2:0] K_DONE = 3'd4;

    localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
    localparam logic [7:0] CMD_READ     = 8'h20;
    localparam logic [7:0] CMD_WRITE    = 8'h30;
    localparam logic [7:0] CMD_FLUSH    = 8'hE7;
    localparam logic [31:0] LBA_MAX     = 32'h0FFF_FFFF;

    typedef enum logic [4:0] {
        P_IDLE, P_ID_SETTLE, P_ID_STATUS1, P_ID_BUSY, P_ID_MID, P_ID_HIGH,
        P_ID_DRQ, P_ID_DATA, P_SEL_BUSY, P_SEL_SETTLE, P_SEL_DRQ, P_RD_DATA,
        P_RD_SETTLE, P_WR_DATA, P_WR_BUSY, P_WR_FINAL
    } t_phase;

    typedef struct packed {
        logic [2:0]  kind;
        logic [9:0]  port;
        logic        word_access;
        logic [15:0] data_out;
        logic        last;
        logic        ok;
        logic [1:0]  device_index;
        logic        device_present;
    } t_res;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] lba;
        logic [15:0] value;
    } t_req;

    typedef struct packed {
        logic [3:0] count;
        t_res [MAX_RES-1:0] res;
    } t_batch;

endpackage

// ===== hdl/ata_if.sv =====
interface ata_in_if;
    logic           valid;
    logic           ready;
    ata_pkg::t_req  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ata_out_if;
    logic           valid;
    logic           ready;
    ata_pkg::t_res  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ata_cfg_if;
    logic        valid;
    logic        ready;
    logic [19:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/ata_step.sv =====
module ata_step #(
    parameter int unsigned SECTOR_WORDS = ata_pkg::SECTOR_WORDS_DEF,
    parameter int unsigned SETTLE_READS = ata_pkg::SETTLE_READS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  ata_pkg::t_req        i_req,
    input  logic [19:0]          i_poll_limit,
    output ata_pkg::t_batch      o_batch
);

    ata_pkg::t_phase r_phase, n_phase;
    logic [1:0]  r_pend, n_pend;
    logic [19:0] r_poll, n_poll;
    logic [8:0]  r_words, n_words;
    logic [2:0]  r_disc, n_disc;
    logic [1:0]  r_slot, n_slot;
    logic        r_pres, n_pres;
    logic [27:0] r_lba, n_lba;
    ata_pkg::t_batch b;

    always_comb begin
        logic [9:0] io, ctl;
        logic [19:0] pc1;
        logic [8:0] wc1;
        logic [2:0] dc1;
        logic bfail, bdone, dfail, ddone, pexp;
        logic sfail;
        logic [15:0] vv;
        n_phase = r_phase; n_pend = r_pend; n_poll = r_poll; n_words = r_words;
        n_disc = r_disc; n_slot = r_slot; n_pres = r_pres; n_lba = r_lba;
        b = '0;
        io = r_slot[1] ? 10'h170 : 10'h1F0;
        ctl = r_slot[1] ? 10'h376 : 10'h3F6;
        vv = i_req.value;
        pc1 = r_poll + 20'd1;
        wc1 = r_words + 9'd1;
        dc1 = r_disc + 3'd1;
        pexp = (pc1 >= i_poll_limit);
        bfail = (vv == 16'hFF) || (vv[7] && pexp);
        bdone = (vv != 16'hFF) && !vv[7];
        dfail = (vv == 16'h0) || (vv == 16'hFF) || (vv[5] | vv[0]) ||
                (!(!vv[7] && vv[3]) && pexp);
        ddone = !dfail && !vv[7] && vv[3];
        sfail = 1'b0;
        if (i_go) begin
            case (r_phase)
                ata_pkg::P_IDLE: begin
                    if (i_req.operation == ata_pkg::OP_PROBE) begin
                        if (r_pres) begin
                            b.res[0].kind = ata_pkg::K_DONE; b.res[0].ok = 1'b1;
                            b.count = 4'd1;
                        end else begin
                            n_slot = 2'd0; n_pend = 2'd0;
                            sfail = 1'b1;
                        end
                    end else if (i_req.operation == ata_pkg::OP_READ ||
                                 i_req.operation == ata_pkg::OP_WRITE) begin
                        b.count = 4'd1;
                        if (!r_pres || i_req.lba > ata_pkg::LBA_MAX ||
                            i_poll_limit == 20'd0) begin
                            b.res[0].kind = ata_pkg::K_DONE;
                            if (r_pres && i_req.lba <= ata_pkg::LBA_MAX) begin
                                n_lba = i_req.lba[27:0];
                                n_pend = i_req.operation[1:0];
                                n_poll = '0;
                            end
                        end else begin
                            n_lba = i_req.lba[27:0];
                            n_pend = i_req.operation[1:0];
                            n_poll = '0;
                            n_phase = ata_pkg::P_SEL_BUSY;
                            b.res[0].kind = ata_pkg::K_RD; b.res[0].port = io + 10'd7;
                        end
                    end
                end
                ata_pkg::P_WR_DATA: begin
                    if (i_req.operation == ata_pkg::OP_WDATA) begin
                        b.res[0].kind = ata_pkg::K_WR; b.res[0].port = io;
                        b.res[0].word_access = 1'b1; b.res[0].data_out = vv;
                        n_words = wc1;
                        b.count = 4'd1;
                        if (32'(wc1) >= SECTOR_WORDS) begin
                            b.res[1].kind = ata_pkg::K_WR; b.res[1].port = io + 10'd7;
                            b.res[1].data_out = {8'h0, ata_pkg::CMD_FLUSH};
                            b.count = 4'd3;
                            n_poll = '0;
                            if (i_poll_limit == 20'd0) begin
                                b.res[2].kind = ata_pkg::K_DONE; n_phase = ata_pkg::P_IDLE;
                            end else begin
                                b.res[2].kind = ata_pkg::K_RD; b.res[2].port = io + 10'd7;
                                n_phase = ata_pkg::P_WR_BUSY;
                            end
                        end
                    end
                end
                default: begin
                    if (i_req.operation == ata_pkg::OP_RET) begin
                        b.count = 4'd1;
                        b.res[0].kind = ata_pkg::K_RD;
                        b.res[0].port = io + 10'd7;
                        case (r_phase)
                            ata_pkg::P_ID_SETTLE, ata_pkg::P_SEL_SETTLE,
                            ata_pkg::P_RD_SETTLE: begin
                                n_disc = dc1;
                                if (32'(dc1) < SETTLE_READS) begin
                                    b.res[0].port = ctl;
                                end else if (r_phase == ata_pkg::P_RD_SETTLE) begin
                                    b.res[0] = '0; b.res[0].kind = ata_pkg::K_DONE;
                                    b.res[0].ok = 1'b1; n_phase = ata_pkg::P_IDLE;
                                end else if (r_phase == ata_pkg::P_ID_SETTLE) begin
                                    for (int i = 0; i < 4; i++) begin
                                        b.res[i].kind = ata_pkg::K_WR;
                                        b.res[i].port = io + 10'(i + 2);
                                        b.res[i].data_out = '0;
                                    end
                                    b.res[4].kind = ata_pkg::K_WR;
                                    b.res[4].port = io + 10'd7;
                                    b.res[4].data_out = {8'h0, ata_pkg::CMD_IDENTIFY};
                                    b.res[5].kind = ata_pkg::K_RD;
                                    b.res[5].port = io + 10'd7;
                                    b.count = 4'd6;
                                    n_phase = ata_pkg::P_ID_STATUS1;
                                end else begin
                                    for (int i = 0; i < 5; i++) begin
                                        b.res[i].kind = ata_pkg::K_WR;
                                        b.res[i].port = io + 10'(i + 1);
                                    end
                                    b.res[0].data_out = '0;
                                    b.res[1].data_out = 16'd1;
                                    b.res[2].data_out = {8'h0, r_lba[7:0]};
                                    b.res[3].data_out = {8'h0, r_lba[15:8]};
                                    b.res[4].data_out = {8'h0, r_lba[23:16]};
                                    b.res[5].kind = ata_pkg::K_WR;
                                    b.res[5].port = io + 10'd7;
                                    b.res[5].data_out = {8'h0, (r_pend == 2'd2) ?
                                        ata_pkg::CMD_WRITE : ata_pkg::CMD_READ};
                                    b.count = 4'd7;
                                    n_poll = '0;
                                    if (i_poll_limit == 20'd0) begin
                                        b.res[6].kind = ata_pkg::K_DONE;
                                        n_phase = ata_pkg::P_IDLE;
                                    end else begin
                                        b.res[6].kind = ata_pkg::K_RD;
                                        b.res[6].port = io + 10'd7;
                                        n_phase = ata_pkg::P_SEL_DRQ;
                                    end
                                end
                            end
                            ata_pkg::P_ID_STATUS1: begin
                                if (vv == 16'h0 || vv == 16'hFF || i_poll_limit == 20'd0) begin
                                    n_poll = (vv == 16'h0 || vv == 16'hFF) ? r_poll : '0;
                                    b.count = 4'd0; sfail = 1'b1;
                                    if (r_slot != 2'd3) n_slot = r_slot + 2'd1;
                                end else begin
                                    n_poll = '0; n_phase = ata_pkg::P_ID_BUSY;
                                end
                            end
                            ata_pkg::P_ID_BUSY, ata_pkg::P_SEL_BUSY,
                            ata_pkg::P_WR_BUSY: begin
                                n_poll = pc1;
                                if (bfail) begin
                                    if (r_phase == ata_pkg::P_ID_BUSY) begin
                                        b.count = 4'd0; sfail = 1'b1;
                                        if (r_slot != 2'd3) n_slot = r_slot + 2'd1;
                                    end else begin
                                        b.res[0].kind = ata_pkg::K_DONE;
                                        b.res[0].port = '0; n_phase = ata_pkg::P_IDLE;
                                    end
                                end else if (bdone) begin
                                    case (r_phase)
                                        ata_pkg::P_ID_BUSY: begin
                                            b.res[0].port = io + 10'd4;
                                            n_phase = ata_pkg::P_ID_MID;
                                        end
                                        ata_pkg::P_WR_BUSY: n_phase = ata_pkg::P_WR_FINAL;
                                        default: begin
                                            b.res[0].kind = ata_pkg::K_WR;
                                            b.res[0].port = io + 10'd6;
                                            b.res[0].data_out = {8'h0, 3'b111, r_slot[0],
                                                                 r_lba[27:24]};
                                            b.res[1].kind = ata_pkg::K_RD;
                                            b.res[1].port = ctl;
                                            b.count = 4'd2;
                                            n_disc = '0;
                                            n_phase = ata_pkg::P_SEL_SETTLE;
                                        end
                                    endcase
                                end
                            end
                            ata_pkg::P_ID_MID: begin
                                if (vv != 16'h0) begin
                                    b.count = 4'd0; sfail = 1'b1;
                                    if (r_slot != 2'd3) n_slot = r_slot + 2'd1;
                                end else begin
                                    b.res[0].port = io + 10'd5; n_phase = ata_pkg::P_ID_HIGH;
                                end
                            end
                            ata_pkg::P_ID_HIGH: begin
                                if (vv != 16'h0 || i_poll_limit == 20'd0) begin
                                    if (vv == 16'h0) n_poll = '0;
                                    b.count = 4'd0; sfail = 1'b1;
                                    if (r_slot != 2'd3) n_slot = r_slot + 2'd1;
                                end else begin
                                    n_poll = '0; n_phase = ata_pkg::P_ID_DRQ;
                                end
                            end
                            ata_pkg::P_ID_DRQ, ata_pkg::P_SEL_DRQ: begin
                                n_poll = pc1;
                                if (dfail) begin
                                    if (r_phase == ata_pkg::P_ID_DRQ) begin
                                        b.count = 4'd0; sfail = 1'b1;
                                        if (r_slot != 2'd3) n_slot = r_slot + 2'd1;
                                    end else begin
                                        b.res[0].kind = ata_pkg::K_DONE;
                                        b.res[0].port = '0; n_phase = ata_pkg::P_IDLE;
                                    end
                                end else if (ddone) begin
                                    n_words = '0;
                                    if (r_phase == ata_pkg::P_SEL_DRQ && r_pend == 2'd2) begin
                                        b.res[0].kind = ata_pkg::K_OPEN;
                                        b.res[0].port = '0;
                                        n_phase = ata_pkg::P_WR_DATA;
                                    end else begin
                                        b.res[0].port = io; b.res[0].word_access = 1'b1;
                                        n_phase = (r_phase == ata_pkg::P_ID_DRQ) ?
                                            ata_pkg::P_ID_DATA : ata_pkg::P_RD_DATA;
                                    end
                                end
                            end
                            ata_pkg::P_ID_DATA: begin
                                n_words = wc1;
                                if (32'(wc1) < SECTOR_WORDS) begin
                                    b.res[0].port = io; b.res[0].word_access = 1'b1;
                                end else begin
                                    n_pres = 1'b1;
                                    b.res[0].kind = ata_pkg::K_DONE; b.res[0].port = '0;
                                    b.res[0].ok = 1'b1; n_phase = ata_pkg::P_IDLE;
                                end
                            end
                            ata_pkg::P_RD_DATA: begin
                                n_words = wc1;
                                b.res[0].kind = ata_pkg::K_HOST; b.res[0].port = '0;
                                b.res[0].data_out = vv;
                                b.res[0].last = (32'(wc1) >= SECTOR_WORDS);
                                b.count = 4'd2;
                                if (32'(wc1) < SECTOR_WORDS) begin
                                    b.res[1].kind = ata_pkg::K_RD; b.res[1].port = io;
                                    b.res[1].word_access = 1'b1;
                                end else begin
                                    b.res[1].kind = ata_pkg::K_RD; b.res[1].port = ctl;
                                    n_disc = '0; n_phase = ata_pkg::P_RD_SETTLE;
                                end
                            end
                            ata_pkg::P_WR_FINAL: begin
                                b.res[0].kind = ata_pkg::K_DONE; b.res[0].port = '0;
                                b.res[0].ok = (vv != 16'h0) && (vv != 16'hFF) &&
                                              !(vv[5] | vv[0]);
                                n_phase = ata_pkg::P_IDLE;
                            end
                            default: begin
                                b.count = 4'd0; n_phase = ata_pkg::P_IDLE;
                            end
                        endcase
                    end
                end
            endcase
            if (sfail) begin
                if (r_phase != ata_pkg::P_IDLE && r_slot == 2'd3) begin
                    n_slot = 2'd0;
                    b.res[0] = '0; b.res[0].kind = ata_pkg::K_DONE;
                    b.count = 4'd1; n_phase = ata_pkg::P_IDLE;
                end else begin
                    io = n_slot[1] ? 10'h170 : 10'h1F0;
                    ctl = n_slot[1] ? 10'h376 : 10'h3F6;
                    b.res[0] = '0; b.res[1] = '0; b.res[2] = '0;
                    b.res[0].kind = ata_pkg::K_WR; b.res[0].port = ctl;
                    b.res[0].data_out = 16'd2;
                    b.res[1].kind = ata_pkg::K_WR; b.res[1].port = io + 10'd6;
                    b.res[1].data_out = n_slot[0] ? 16'hB0 : 16'hA0;
                    b.res[2].kind = ata_pkg::K_RD; b.res[2].port = ctl;
                    b.count = 4'd3; n_disc = '0; n_phase = ata_pkg::P_ID_SETTLE;
                end
            end
            for (int i = 0; i < ata_pkg::MAX_RES; i++) begin
                b.res[i].device_index = n_slot;
                b.res[i].device_present = n_pres;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ata_pkg::P_IDLE; r_pend <= '0; r_poll <= '0; r_words <= '0;
            r_disc <= '0; r_slot <= '0; r_pres <= 1'b0; r_lba <= '0;
        end else begin
            r_phase <= n_phase; r_pend <= n_pend; r_poll <= n_poll; r_words <= n_words;
            r_disc <= n_disc; r_slot <= n_slot; r_pres <= n_pres; r_lba <= n_lba;
        end
    end

    assign o_batch = b;

endmodule

// ===== hdl/ata_out_q.sv =====
module ata_out_q (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ata_pkg::t_batch  i_batch,
    output logic             o_empty,
    output logic             o_last_out,
    ata_out_if.source        o_res
);

    ata_pkg::t_res [ata_pkg::MAX_RES-1:0] r_res;
    logic [3:0] r_cnt;
    logic [2:0] r_idx;

    assign o_res.valid = (r_cnt != 4'd0);
    assign o_res.payload = r_res[r_idx];
    assign o_empty = (r_cnt == 4'd0);
    assign o_last_out = (r_cnt == 4'd1) && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_batch.count; r_idx <= '0;
        end else if (o_res.valid && o_res.ready) begin
            r_cnt <= r_cnt - 4'd1; r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_batch.res;
        end
    end

endmodule

// ===== hdl/ata_pio_sector_sequencer.sv =====
// Results of an item appear in the cycle after its transfer, one per cycle while
// o_res.ready is high; the next item is taken in the cycle its batch's final result
// transfers, or while the queue is empty.
// The result queue of eight entries sets when the next item is taken.
// Reset is synchronous, active low; poll_limit returns to 1000000.
module ata_pio_sector_sequencer #(
    parameter int unsigned SECTOR_WORDS = ata_pkg::SECTOR_WORDS_DEF,
    parameter int unsigned SETTLE_READS = ata_pkg::SETTLE_READS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ata_in_if.sink     i_req,
    ata_cfg_if.sink    i_cfg,
    ata_out_if.source  o_res
);

    logic [19:0] r_poll_limit;
    logic q_empty, q_last;
    logic go;
    ata_pkg::t_batch batch;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = q_empty || q_last;
    assign go = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= ata_pkg::POLL_LIMIT_RST;
        end else if (i_cfg.valid) begin
            r_poll_limit <= i_cfg.data;
        end
    end

    ata_step #(.SECTOR_WORDS(SECTOR_WORDS), .SETTLE_READS(SETTLE_READS)) u_step (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_req(i_req.payload),
        .i_poll_limit(r_poll_limit), .o_batch(batch)
    );

    ata_out_q u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(go), .i_batch(batch),
        .o_empty(q_empty), .o_last_out(q_last), .o_res(o_res)
    );

endmodule

// ===== sim/ata_pio_sector_sequencer_test.sv =====
`timescale 1ns / 1ps

module ata_pio_sector_sequencer_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_TARGET = 170;

    localparam logic [15:0] ST_READY = 16'h0050;
    localparam logic [15:0] ST_BUSY  = 16'h0080;
    localparam logic [15:0] ST_DRQ   = 16'h0058;
    localparam logic [15:0] ST_ERR   = 16'h0051;
    localparam logic [15:0] ST_DF    = 16'h0070;
    localparam logic [15:0] ST_DEAD  = 16'h00FF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ata_in_if  req_ch ();
    ata_cfg_if cfg_ch ();
    ata_out_if res_ch ();

    ata_pio_sector_sequencer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the sequencer state.
    logic [19:0]      m_poll_limit;
    ata_pkg::t_phase  m_phase;
    logic [1:0]       m_pending;
    logic [19:0]      m_polls;
    logic [8:0]       m_words;
    logic [2:0]       m_settle;
    logic [1:0]       m_slot;
    logic             m_present;
    logic [27:0]      m_lba;

    ata_pkg::t_res pending_results[$];
    int   error_count = 0;
    int   idle_cycles = 0;
    bit   stall_long = 1'b0;
    int   pass_count = 0;

    function automatic logic [9:0] io_port();
        return (m_slot < 2) ? 10'h1F0 : 10'h170;
    endfunction

    function automatic logic [9:0] ctl_port();
        return (m_slot < 2) ? 10'h3F6 : 10'h376;
    endfunction

    function automatic void push_result(logic [2:0] kind, logic [9:0] port, logic wa,
                                        logic [15:0] data, logic last, logic ok);
        ata_pkg::t_res r;
        r.kind = kind;
        r.port = port;
        r.word_access = wa;
        r.data_out = data;
        r.last = last;
        r.ok = ok;
        r.device_index = m_slot;
        r.device_present = m_present;
        pending_results.push_back(r);
    endfunction

    function automatic void push_done(logic ok);
        m_phase = ata_pkg::P_IDLE;
        push_result(ata_pkg::K_DONE, 10'd0, 1'b0, 16'd0, 1'b0, ok);
    endfunction

    function automatic void push_status_read();
        push_result(ata_pkg::K_RD, io_port() + 10'd7, 1'b0, 16'd0, 1'b0, 1'b0);
    endfunction

    function automatic void begin_identify();
        push_result(ata_pkg::K_WR, ctl_port(), 1'b0, 16'd2, 1'b0, 1'b0);
        push_result(ata_pkg::K_WR, io_port() + 10'd6, 1'b0, m_slot[0] ? 16'hB0 : 16'hA0,
                    1'b0, 1'b0);
        push_result(ata_pkg::K_RD, ctl_port(), 1'b0, 16'd0, 1'b0, 1'b0);
        m_settle = 3'd0;
        m_phase = ata_pkg::P_ID_SETTLE;
    endfunction

    function automatic void next_slot();
        if (m_slot < 3) begin
            m_slot = m_slot + 2'd1;
            begin_identify();
        end else begin
            m_slot = 2'd0;
            push_done(1'b0);
        end
    endfunction

    // 0 fail, 1 done, 2 poll again
    function automatic int busy_poll(logic [15:0] v);
        m_polls = m_polls + 20'd1;
        if (v == 16'hFF) return 0;
        if (!v[7]) return 1;
        return (m_polls >= m_poll_limit) ? 0 : 2;
    endfunction

    function automatic int drq_poll(logic [15:0] v);
        m_polls = m_polls + 20'd1;
        if (v == 16'h0 || v == 16'hFF) return 0;
        if (v[5] || v[0]) return 0;
        if (!v[7] && v[3]) return 1;
        return (m_polls >= m_poll_limit) ? 0 : 2;
    endfunction

    function automatic void predict_sequencer(ata_pkg::t_req q);
        logic [9:0] io;
        int r;
        io = io_port();
        if (m_phase == ata_pkg::P_IDLE) begin
            if (q.operation == ata_pkg::OP_PROBE) begin
                if (m_present) begin
                    push_done(1'b1);
                end else begin
                    m_slot = 2'd0;
                    m_pending = 2'd0;
                    begin_identify();
                end
            end else if (q.operation == ata_pkg::OP_READ ||
                         q.operation == ata_pkg::OP_WRITE) begin
                if (!m_present || q.lba > ata_pkg::LBA_MAX) begin
                    push_done(1'b0);
                end else begin
                    m_lba = q.lba[27:0];
                    m_pending = q.operation[1:0];
                    m_polls = 20'd0;
                    if (m_poll_limit == 0) begin
                        push_done(1'b0);
                    end else begin
                        m_phase = ata_pkg::P_SEL_BUSY;
                        push_status_read();
                    end
                end
            end
            return;
        end
        if (m_phase == ata_pkg::P_WR_DATA) begin
            if (q.operation != ata_pkg::OP_WDATA) return;
            push_result(ata_pkg::K_WR, io, 1'b1, q.value, 1'b0, 1'b0);
            m_words = m_words + 9'd1;
            if (m_words < ata_pkg::SECTOR_WORDS_DEF) return;
            push_result(ata_pkg::K_WR, io + 10'd7, 1'b0, {8'd0, ata_pkg::CMD_FLUSH},
                        1'b0, 1'b0);
            m_polls = 20'd0;
            if (m_poll_limit == 0) begin
                push_done(1'b0);
            end else begin
                m_phase = ata_pkg::P_WR_BUSY;
                push_status_read();
            end
            return;
        end
        if (q.operation != ata_pkg::OP_RET) return;
        case (m_phase)
            ata_pkg::P_ID_SETTLE: begin
                m_settle = m_settle + 3'd1;
                if (m_settle < ata_pkg::SETTLE_READS_DEF) begin
                    push_result(ata_pkg::K_RD, ctl_port(), 1'b0, 16'd0, 1'b0, 1'b0);
                end else begin
                    for (int p = 2; p <= 5; p++)
                        push_result(ata_pkg::K_WR, io + 10'(p), 1'b0, 16'd0, 1'b0, 1'b0);
                    push_result(ata_pkg::K_WR, io + 10'd7, 1'b0,
                                {8'd0, ata_pkg::CMD_IDENTIFY}, 1'b0, 1'b0);
                    m_phase = ata_pkg::P_ID_STATUS1;
                    push_status_read();
                end
            end
            ata_pkg::P_ID_STATUS1: begin
                m_polls = 20'd0;
                if (q.value == 0 || q.value == 16'hFF || m_poll_limit == 0) begin
                    next_slot();
                end else begin
                    m_phase = ata_pkg::P_ID_BUSY;
                    push_status_read();
                end
            end
            ata_pkg::P_ID_BUSY: begin
                r = busy_poll(q.value);
                if (r == 0) next_slot();
                else if (r == 2) push_status_read();
                else begin
                    m_phase = ata_pkg::P_ID_MID;
                    push_result(ata_pkg::K_RD, io + 10'd4, 1'b0, 16'd0, 1'b0, 1'b0);
                end
            end
            ata_pkg::P_ID_MID: begin
                if (q.value != 0) next_slot();
                else begin
                    m_phase = ata_pkg::P_ID_HIGH;
                    push_result(ata_pkg::K_RD, io + 10'd5, 1'b0, 16'd0, 1'b0, 1'b0);
                end
            end
            ata_pkg::P_ID_HIGH: begin
                m_polls = 20'd0;
                if (q.value != 0 || m_poll_limit == 0) next_slot();
                else begin
                    m_phase = ata_pkg::P_ID_DRQ;
                    push_status_read();
                end
            end
            ata_pkg::P_ID_DRQ: begin
                r = drq_poll(q.value);
                if (r == 0) next_slot();
                else if (r == 2) push_status_read();
                else begin
                    m_words = 9'd0;
                    m_phase = ata_pkg::P_ID_DATA;
                    push_result(ata_pkg::K_RD, io, 1'b1, 16'd0, 1'b0, 1'b0);
                end
            end
            ata_pkg::P_ID_DATA: begin
                m_words = m_words + 9'd1;
                if (m_words < ata_pkg::SECTOR_WORDS_DEF) begin
                    push_result(ata_pkg::K_RD, io, 1'b1, 16'd0, 1'b0, 1'b0);
                end else begin
                    m_present = 1'b1;
                    push_done(1'b1);
                end
            end
            ata_pkg::P_SEL_BUSY: begin
                r = busy_poll(q.value);
                if (r == 0) push_done(1'b0);
                else if (r == 2) push_status_read();
                else begin
                    push_result(ata_pkg::K_WR, io + 10'd6, 1'b0,
                                {8'd0, 3'b111, m_slot[0], m_lba[27:24]}, 1'b0, 1'b0);
                    m_settle = 3'd0;
                    m_phase = ata_pkg::P_SEL_SETTLE;
                    push_result(ata_pkg::K_RD, ctl_port(), 1'b0, 16'd0, 1'b0, 1'b0);
                end
            end
            ata_pkg::P_SEL_SETTLE: begin
                m_settle = m_settle + 3'd1;
                if (m_settle < ata_pkg::SETTLE_READS_DEF) begin
                    push_result(ata_pkg::K_RD, ctl_port(), 1'b0, 16'd0, 1'b0, 1'b0);
                end else begin
                    push_result(ata_pkg::K_WR, io + 10'd1, 1'b0, 16'd0, 1'b0, 1'b0);
                    push_result(ata_pkg::K_WR, io + 10'd2, 1'b0, 16'd1, 1'b0, 1'b0);
                    push_result(ata_pkg::K_WR, io + 10'd3, 1'b0, {8'd0, m_lba[7:0]},
                                1'b0, 1'b0);
                    push_result(ata_pkg::K_WR, io + 10'd4, 1'b0, {8'd0, m_lba[15:8]},
                                1'b0, 1'b0);
                    push_result(ata_pkg::K_WR, io + 10'd5, 1'b0, {8'd0, m_lba[23:16]},
                                1'b0, 1'b0);
                    push_result(ata_pkg::K_WR, io + 10'd7, 1'b0,
                                {8'd0, (m_pending == ata_pkg::OP_WRITE[1:0]) ?
                                 ata_pkg::CMD_WRITE : ata_pkg::CMD_READ},
                                1'b0, 1'b0);
                    m_polls = 20'd0;
                    if (m_poll_limit == 0) push_done(1'b0);
                    else begin
                        m_phase = ata_pkg::P_SEL_DRQ;
                        push_status_read();
                    end
                end
            end
            ata_pkg::P_SEL_DRQ: begin
                r = drq_poll(q.value);
                if (r == 0) push_done(1'b0);
                else if (r == 2) push_status_read();
                else begin
                    m_words = 9'd0;
                    if (m_pending == ata_pkg::OP_WRITE[1:0]) begin
                        m_phase = ata_pkg::P_WR_DATA;
                        push_result(ata_pkg::K_OPEN, 10'd0, 1'b0, 16'd0, 1'b0, 1'b0);
                    end else begin
                        m_phase = ata_pkg::P_RD_DATA;
                        push_result(ata_pkg::K_RD, io, 1'b1, 16'd0, 1'b0, 1'b0);
                    end
                end
            end
            ata_pkg::P_RD_DATA: begin
                m_words = m_words + 9'd1;
                push_result(ata_pkg::K_HOST, 10'd0, 1'b0, q.value,
                            (m_words >= ata_pkg::SECTOR_WORDS_DEF), 1'b0);
                if (m_words < ata_pkg::SECTOR_WORDS_DEF) begin
                    push_result(ata_pkg::K_RD, io, 1'b1, 16'd0, 1'b0, 1'b0);
                end else begin
                    m_settle = 3'd0;
                    m_phase = ata_pkg::P_RD_SETTLE;
                    push_result(ata_pkg::K_RD, ctl_port(), 1'b0, 16'd0, 1'b0, 1'b0);
                end
            end
            ata_pkg::P_RD_SETTLE: begin
                m_settle = m_settle + 3'd1;
                if (m_settle < ata_pkg::SETTLE_READS_DEF)
                    push_result(ata_pkg::K_RD, ctl_port(), 1'b0, 16'd0, 1'b0, 1'b0);
                else
                    push_done(1'b1);
            end
            ata_pkg::P_WR_BUSY: begin
                r = busy_poll(q.value);
                if (r == 0) push_done(1'b0);
                else if (r == 2) push_status_read();
                else begin
                    m_phase = ata_pkg::P_WR_FINAL;
                    push_status_read();
                end
            end
            ata_pkg::P_WR_FINAL: begin
                push_done(q.value != 0 && q.value != 16'hFF && !q.value[5] && !q.value[0]);
            end
            default: m_phase = ata_pkg::P_IDLE;
        endcase
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_long) begin
                res_ch.ready = 1'b0;
                repeat (300) @(negedge i_clk);
                stall_long = 1'b0;
            end
            stall = $urandom_range(0, 99);
            if (pass_count > 0) res_ch.ready = 1'b1;
            else if (stall < 70) res_ch.ready = 1'b1;
            else if (stall < 97) res_ch.ready = 1'b0;
            else begin
                res_ch.ready = 1'b0;
                repeat ($urandom_range(5, 30)) @(negedge i_clk);
                res_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        ata_pkg::t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, res_ch.payload);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_ch.payload !== want) begin
                    $display("%0t: result mismatch expected %h actual %h",
                             $time, want, res_ch.payload);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Valid stays high after a transfer until the next item or an idle gap replaces it.
    task automatic send_item(logic [2:0] op, logic [31:0] lba, logic [15:0] value);
        ata_pkg::t_req q;
        int gap;
        gap = $urandom_range(0, 99);
        if (pass_count == 0) begin
            if (gap >= 90) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(6, 25)) @(negedge i_clk);
            end else if (gap >= 55) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
            end
        end
        q.operation = op;
        q.lba = lba;
        q.value = value;
        req_ch.payload <= q;
        req_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_sequencer(q);
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_poll_limit(logic [19:0] limit);
        drain();
        cfg_ch.data <= limit;
        cfg_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        m_poll_limit = limit;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Answers the bus reads of an IDENTIFY on the current slot, with a busy poll.
    task automatic identify_ok();
        repeat (4) send_item(ata_pkg::OP_RET, $urandom, 16'h0);
        send_item(ata_pkg::OP_RET, 32'd0, ST_BUSY);
        send_item(ata_pkg::OP_RET, 32'd0, ST_BUSY);
        send_item(ata_pkg::OP_RET, 32'd0, ST_READY);
        send_item(ata_pkg::OP_RET, 32'd0, 16'h0);
        send_item(ata_pkg::OP_RET, 32'd0, 16'h0);
        send_item(ata_pkg::OP_RET, 32'd0, ST_DRQ);
        repeat (ata_pkg::SECTOR_WORDS_DEF) send_item(ata_pkg::OP_RET, 32'd0, 16'($urandom));
    endtask

    task automatic sector_access(logic [2:0] op, logic [31:0] lba, bit noisy);
        send_item(op, lba, 16'($urandom));
        if (m_phase == ata_pkg::P_IDLE) return;
        repeat ($urandom_range(0, 2)) send_item(ata_pkg::OP_RET, 32'd0, ST_BUSY);
        send_item(ata_pkg::OP_RET, 32'd0,
                  (noisy && $urandom_range(0, 3) == 0) ? ST_DEAD : ST_READY);
        if (m_phase == ata_pkg::P_IDLE) return;
        repeat (4) send_item(ata_pkg::OP_RET, 32'd0, 16'($urandom));
        repeat ($urandom_range(0, 2)) send_item(ata_pkg::OP_RET, 32'd0, ST_BUSY);
        if (noisy && $urandom_range(0, 3) == 0)
            send_item(ata_pkg::OP_RET, 32'd0, ($urandom_range(0, 1) != 0) ? ST_ERR : ST_DF);
        else
            send_item(ata_pkg::OP_RET, 32'd0, ST_DRQ);
        if (m_phase == ata_pkg::P_IDLE) return;
        if (op == ata_pkg::OP_READ) begin
            while (m_phase == ata_pkg::P_RD_DATA)
                send_item(ata_pkg::OP_RET, 32'd0, 16'($urandom));
            while (m_phase == ata_pkg::P_RD_SETTLE)
                send_item(ata_pkg::OP_RET, 32'd0, 16'($urandom));
        end else begin
            if (noisy) send_item(ata_pkg::OP_RET, 32'd0, 16'($urandom));
            while (m_phase == ata_pkg::P_WR_DATA)
                send_item(ata_pkg::OP_WDATA, $urandom, 16'($urandom));
            repeat ($urandom_range(0, 2)) send_item(ata_pkg::OP_RET, 32'd0, ST_BUSY);
            send_item(ata_pkg::OP_RET, 32'd0, ST_READY);
            send_item(ata_pkg::OP_RET, 32'd0,
                      (noisy && $urandom_range(0, 1) != 0) ? ST_ERR : ST_READY);
        end
    endtask

    typedef struct {
        logic [2:0]  op;
        logic [31:0] lba;
        logic [15:0] value;
        bit          typed;
        logic [2:0]  kind;
        logic        ok;
    } t_row;

    t_row directed_rows[] = '{
        '{ata_pkg::OP_READ,  32'h0000_0000, 16'h0000, 1'b1, ata_pkg::K_DONE, 1'b0},
        '{ata_pkg::OP_WRITE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, ata_pkg::K_DONE, 1'b0},
        '{ata_pkg::OP_RET,   32'h0000_0000, 16'h0050, 1'b0, ata_pkg::K_RD,   1'b0},
        '{ata_pkg::OP_WDATA, 32'h0000_0000, 16'h1234, 1'b0, ata_pkg::K_RD,   1'b0},
        '{3'd5,              32'h0000_0000, 16'h0000, 1'b0, ata_pkg::K_RD,   1'b0},
        '{3'd7,              32'hFFFF_FFFF, 16'hFFFF, 1'b0, ata_pkg::K_RD,   1'b0},
        '{ata_pkg::OP_PROBE, 32'h0000_0000, 16'h0000, 1'b1, ata_pkg::K_WR,   1'b0}
    };

    initial begin
        ata_pkg::t_req idle_req;
        int gotten;
        int choice;
        idle_req = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = idle_req;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 20'd0;
        m_poll_limit = ata_pkg::POLL_LIMIT_RST;
        m_phase = ata_pkg::P_IDLE;
        m_pending = 2'd0;
        m_polls = 20'd0;
        m_words = 9'd0;
        m_settle = 3'd0;
        m_slot = 2'd0;
        m_present = 1'b0;
        m_lba = 28'd0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            drain();
            gotten = pending_results.size();
            send_item(directed_rows[i].op, directed_rows[i].lba, directed_rows[i].value);
            if (directed_rows[i].typed
                    && (pending_results.size() == gotten
                        || pending_results[gotten].kind !== directed_rows[i].kind
                        || pending_results[gotten].ok !== directed_rows[i].ok)) begin
                $display("%0t: row %0d expected kind %0d ok %0d actual kind %0d ok %0d",
                         $time, i, directed_rows[i].kind, directed_rows[i].ok,
                         pending_results[gotten].kind, pending_results[gotten].ok);
                error_count++;
            end
        end
        // Slot 0 gets no answer, slot 1 a dead bus, slot 2 a timeout, slot 3 a nonzero
        // signature, then a whole probe fails back to slot 0.
        repeat (4) send_item(ata_pkg::OP_RET, 32'd0, 16'h0);
        send_item(ata_pkg::OP_RET, 32'd0, 16'h0);
        repeat (4) send_item(ata_pkg::OP_RET, 32'd0, 16'h0);
        send_item(ata_pkg::OP_RET, 32'd0, ST_DEAD);
        drain();
        write_poll_limit(20'd2);
        // The probe is still running; settings only change between transfers here
        // since the block is waiting on an answer, not working.
        repeat (4) send_item(ata_pkg::OP_RET, 32'd0, 16'h0);
        send_item(ata_pkg::OP_RET, 32'd0, ST_BUSY);
        send_item(ata_pkg::OP_RET, 32'd0, ST_BUSY);
        send_item(ata_pkg::OP_RET, 32'd0, ST_BUSY);
        repeat (4) send_item(ata_pkg::OP_RET, 32'd0, 16'h0);
        send_item(ata_pkg::OP_RET, 32'd0, ST_READY);
        send_item(ata_pkg::OP_RET, 32'd0, ST_READY);
        send_item(ata_pkg::OP_RET, 32'd0, 16'h14);
        write_poll_limit(20'd0);
        send_item(ata_pkg::OP_PROBE, 32'd0, 16'd0);
        repeat (4) send_item(ata_pkg::OP_RET, 32'd0, 16'h0);
        repeat (4) begin
            send_item(ata_pkg::OP_RET, 32'd0, ST_READY);
            if (m_phase != ata_pkg::P_IDLE) repeat (4) send_item(ata_pkg::OP_RET, 32'd0, 16'h0);
        end
        write_poll_limit(20'hFFFFF);
        send_item(ata_pkg::OP_PROBE, 32'd0, 16'd0);
        send_item(ata_pkg::OP_RET, 32'hFFFF_FFFF, 16'hFFFF);
        repeat (3) send_item(ata_pkg::OP_RET, 32'd0, 16'h0);
        send_item(ata_pkg::OP_RET, 32'd0, ST_READY);
        send_item(ata_pkg::OP_RET, 32'd0, 16'h1);
        repeat (4) send_item(ata_pkg::OP_RET, 32'd0, 16'h0);
        identify_ok();
        send_item(ata_pkg::OP_PROBE, 32'd0, 16'd0);
        sector_access(ata_pkg::OP_WRITE, 32'h1000_0000, 1'b0);
        sector_access(ata_pkg::OP_READ, 32'h0FFF_FFFF, 1'b0);

        // Fill the block while results are held off.
        drain();
        stall_long = 1'b1;
        sector_access(ata_pkg::OP_READ, 32'h0ABC_DEF1, 1'b0);
        drain();
        write_poll_limit(20'd1);
        sector_access(ata_pkg::OP_WRITE, 32'h0000_0001, 1'b0);
        write_poll_limit(ata_pkg::POLL_LIMIT_RST);

        for (int n = 0; n < RANDOM_TARGET / 20; n++) begin
            choice = $urandom_range(0, 9);
            if (choice < 4)
                sector_access(ata_pkg::OP_READ, $urandom & 32'h0FFF_FFFF, 1'b1);
            else if (choice < 8)
                sector_access(ata_pkg::OP_WRITE, $urandom & 32'h0FFF_FFFF, 1'b1);
            else begin
                send_item(3'($urandom_range(0, 7)), $urandom, 16'($urandom));
                while (m_phase != ata_pkg::P_IDLE)
                    send_item(($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) :
                              ata_pkg::OP_RET, $urandom, 16'($urandom));
            end
            if (n == 3) begin
                drain();
                pass_count = 1;
                sector_access(ata_pkg::OP_READ, $urandom & 32'h0FFF_FFFF, 1'b0);
                pass_count = 0;
            end
        end
        drain();
        repeat (20) @(negedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/ata_pkg.sv
hdl/ata_if.sv
hdl/ata_step.sv
hdl/ata_out_q.sv
hdl/ata_pio_sector_sequencer.sv
sim/ata_pio_sector_sequencer_test.sv
